[hdl/dibsp_pkg.sv]
// Shared types, constants and a colour helper for the DIB to sprite byte converter.
`timescale 1ns / 1ps

package dibsp_pkg;

    localparam int DEF_MAX_WIDTH     = 4096;
    localparam int DEF_MAX_HEIGHT    = 4096;
    localparam int DEF_PALETTE_DEPTH = 256;

    localparam int DIM_W    = 13;   // width and height registers
    localparam int LEN_W    = 15;   // DIB row byte counts, up to three bytes per pixel
    localparam int SRW_W    = 14;   // sprite row width in bytes
    localparam int OFFSET_W = 24;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        MODE_1BPP  = 2'd0,
        MODE_4BPP  = 2'd1,
        MODE_8BPP  = 2'd2,
        MODE_24BPP = 2'd3
    } pixel_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PIXEL_MODE   = 2'd0,
        CFG_IMAGE_WIDTH  = 2'd1,
        CFG_IMAGE_HEIGHT = 2'd2,
        CFG_UNUSED       = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        PHASE_BLUE  = 2'd0,
        PHASE_GREEN = 2'd1,
        PHASE_RED   = 2'd2
    } phase_t;

    // Geometry derived from the configuration registers
    typedef struct packed {
        pixel_mode_t         mode;
        logic [LEN_W-1:0]    data_len;
        logic [LEN_W-1:0]    padded_len;
        logic [SRW_W-1:0]    row_width;
        logic [DIM_W-1:0]    top_row;
        logic [OFFSET_W-1:0] top_base;
    } geom_t;

    // Payload of the middle stage
    typedef struct packed {
        logic [OFFSET_W-1:0] offset;
        logic [7:0]          direct_byte;
        logic                last;
        logic                use_palette;
    } mid_t;

    function automatic logic [7:0] reduce_colour(input logic [7:0] r, input logic [7:0] g,
                                                 input logic [7:0] b);
        logic [7:0] any_bits;
        logic [7:0] v;
        any_bits = r | g | b;
        v = {b[7], g[7], g[6], r[7], b[6], r[6], any_bits[5], any_bits[4]};
        return v;
    endfunction

endpackage

[hdl/dibsp_cfg.sv]
// Configuration registers and the row geometry derived from them.
`timescale 1ns / 1ps

module dibsp_cfg
    import dibsp_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_wdata,
    output geom_t                geom,
    output geom_t                geom_load,
    output logic                 restart
);

    localparam logic [31:0] MaxW32 = 32'(MAX_WIDTH);
    localparam logic [31:0] MaxH32 = 32'(MAX_HEIGHT);

    pixel_mode_t       mode_reg, mode_next;
    logic [DIM_W-1:0]  width_reg, width_next;
    logic [DIM_W-1:0]  height_reg, height_next;
    geom_t             geom_reg;

    logic [DIM_W-1:0]  eff_w;
    logic [DIM_W-1:0]  eff_h;
    logic [LEN_W-1:0]  w_ext;
    logic [LEN_W-1:0]  dlen;
    logic [SRW_W-1:0]  srw;
    logic [SRW_W-1:0]  w_srw;
    logic [DIM_W+SRW_W-1:0] product;

    always_comb
    begin
        mode_next   = mode_reg;
        width_next  = width_reg;
        height_next = height_reg;
        restart     = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PIXEL_MODE:
                begin
                    mode_next = pixel_mode_t'(cfg_wdata[1:0]);
                    restart   = 1'b1;
                end
                CFG_IMAGE_WIDTH:
                begin
                    width_next = cfg_wdata;
                    restart    = 1'b1;
                end
                CFG_IMAGE_HEIGHT:
                begin
                    height_next = cfg_wdata;
                    restart     = 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Geometry of the configuration being written
    always_comb
    begin
        eff_w = width_next;
        if (width_next == '0)
            eff_w = DIM_W'(1);
        else if (32'(width_next) > MaxW32)
            eff_w = MaxW32[DIM_W-1:0];

        eff_h = height_next;
        if (height_next == '0)
            eff_h = DIM_W'(1);
        else if (32'(height_next) > MaxH32)
            eff_h = MaxH32[DIM_W-1:0];

        w_ext = LEN_W'(eff_w);
        w_srw = SRW_W'(eff_w);
        unique case (mode_next)
            MODE_1BPP:
            begin
                dlen = (w_ext + LEN_W'(7)) >> 3;
                srw  = ((w_srw + SRW_W'(31)) >> 5) << 2;
            end
            MODE_4BPP:
            begin
                dlen = (w_ext + LEN_W'(1)) >> 1;
                srw  = ((w_srw + SRW_W'(7)) >> 3) << 2;
            end
            MODE_8BPP:
            begin
                dlen = w_ext;
                srw  = ((w_srw + SRW_W'(3)) >> 2) << 2;
            end
            default:
            begin
                dlen = (w_ext << 1) + w_ext;
                srw  = ((w_srw + SRW_W'(3)) >> 2) << 2;
            end
        endcase

        geom_load.mode       = mode_next;
        geom_load.data_len   = dlen;
        geom_load.padded_len = (dlen + LEN_W'(3)) & ~LEN_W'(3);
        geom_load.row_width  = srw;
        geom_load.top_row    = eff_h - DIM_W'(1);
        product              = (DIM_W+SRW_W)'(geom_load.top_row) * (DIM_W+SRW_W)'(srw);
        geom_load.top_base   = product[OFFSET_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg            <= MODE_8BPP;
            width_reg           <= DIM_W'(1);
            height_reg          <= DIM_W'(1);
            geom_reg.mode       <= MODE_8BPP;
            geom_reg.data_len   <= LEN_W'(1);
            geom_reg.padded_len <= LEN_W'(4);
            geom_reg.row_width  <= SRW_W'(4);
            geom_reg.top_row    <= '0;
            geom_reg.top_base   <= '0;
        end
        else if (restart)
        begin
            mode_reg   <= mode_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            geom_reg   <= geom_load;
        end
    end

    assign geom = geom_reg;

endmodule

[hdl/dibsp_palette.sv]
// Palette memory with a registered read port; out-of-range indexes read as black.
`timescale 1ns / 1ps

module dibsp_palette
#(
    parameter int PALETTE_DEPTH = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [7:0]  wr_index,
    input  logic [23:0] wr_rgb,
    input  logic        rd_en,
    input  logic [7:0]  rd_index,
    output logic [23:0] rd_rgb
);

    localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam logic [8:0] Depth9 = 9'(PALETTE_DEPTH);

    logic [23:0] mem [PALETTE_DEPTH];
    logic [23:0] rd_data_reg;
    logic        rd_zero_reg;
    logic        wr_ok;
    logic        rd_ok;

    assign wr_ok = ({1'b0, wr_index} < Depth9);
    assign rd_ok = ({1'b0, rd_index} < Depth9);

    always_ff @(posedge clk)
    begin
        if (wr_en && wr_ok)
            mem[wr_index[AW-1:0]] <= wr_rgb;
        if (rd_en && rd_ok)
            rd_data_reg <= mem[rd_index[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_zero_reg <= 1'b0;
        else if (rd_en)
            rd_zero_reg <= !rd_ok;
    end

    assign rd_rgb = rd_zero_reg ? 24'd0 : rd_data_reg;

endmodule

[hdl/dibsp_track.sv]
// Stream position tracking and per-byte conversion into the middle stage.
`timescale 1ns / 1ps

module dibsp_track
    import dibsp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  geom_t      geom,
    input  geom_t      geom_load,
    input  logic       restart,
    input  logic       advance,
    input  logic       pix_fire,
    input  logic [7:0] data_byte,
    output logic       mid_valid,
    output mid_t       mid
);

    logic [DIM_W-1:0]    row_reg, row_next;
    logic [LEN_W-1:0]    pos_reg, pos_next;
    logic [DIM_W-1:0]    col3_reg, col3_next;
    phase_t              phase_reg, phase_next;
    logic [7:0]          blue_reg, blue_next;
    logic [7:0]          green_reg, green_next;
    logic [OFFSET_W-1:0] base_reg, base_next;
    logic                mid_valid_reg;
    mid_t                mid_reg, mid_next;

    logic [LEN_W-1:0]    pos_inc;
    logic                in_row;
    logic                emit;
    logic [7:0]          rev;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
            rev[7-i] = data_byte[i];
    end

    always_comb
    begin
        row_next   = row_reg;
        pos_next   = pos_reg;
        col3_next  = col3_reg;
        phase_next = phase_reg;
        blue_next  = blue_reg;
        green_next = green_reg;
        base_next  = base_reg;
        emit       = 1'b0;

        pos_inc = pos_reg + LEN_W'(1);
        in_row  = (pos_reg < geom.data_len);

        mid_next.direct_byte = data_byte;
        mid_next.use_palette = 1'b0;
        mid_next.offset      = base_reg + OFFSET_W'(pos_reg);
        mid_next.last        = (row_reg == '0) && (pos_inc == geom.data_len);

        unique case (geom.mode)
            MODE_1BPP:
            begin
                mid_next.direct_byte = rev;
                emit = in_row;
            end
            MODE_4BPP:
            begin
                mid_next.direct_byte = {data_byte[3:0], data_byte[7:4]};
                emit = in_row;
            end
            MODE_8BPP:
            begin
                mid_next.use_palette = 1'b1;
                emit = in_row;
            end
            default:
            begin
                mid_next.direct_byte = reduce_colour(data_byte, green_reg, blue_reg);
                mid_next.offset      = base_reg + OFFSET_W'(col3_reg);
                if (in_row)
                begin
                    case (phase_reg)
                        PHASE_BLUE:
                        begin
                            blue_next  = data_byte;
                            phase_next = PHASE_GREEN;
                        end
                        PHASE_GREEN:
                        begin
                            green_next = data_byte;
                            phase_next = PHASE_RED;
                        end
                        default:
                        begin
                            emit       = 1'b1;
                            col3_next  = col3_reg + DIM_W'(1);
                            phase_next = PHASE_BLUE;
                        end
                    endcase
                end
            end
        endcase

        // End of the padded DIB row: step one sprite row up, or wrap to the top
        if (pos_inc >= geom.padded_len)
        begin
            pos_next   = '0;
            col3_next  = '0;
            phase_next = PHASE_BLUE;
            if (row_reg == '0)
            begin
                row_next   = geom.top_row;
                base_next  = geom.top_base;
                blue_next  = '0;
                green_next = '0;
            end
            else
            begin
                row_next  = row_reg - DIM_W'(1);
                base_next = base_reg - OFFSET_W'(geom.row_width);
            end
        end
        else
        begin
            pos_next = pos_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg   <= '0;
            pos_reg   <= '0;
            col3_reg  <= '0;
            phase_reg <= PHASE_BLUE;
            blue_reg  <= '0;
            green_reg <= '0;
            base_reg  <= '0;
        end
        else if (restart)
        begin
            row_reg   <= geom_load.top_row;
            pos_reg   <= '0;
            col3_reg  <= '0;
            phase_reg <= PHASE_BLUE;
            blue_reg  <= '0;
            green_reg <= '0;
            base_reg  <= geom_load.top_base;
        end
        else if (pix_fire)
        begin
            row_reg   <= row_next;
            pos_reg   <= pos_next;
            col3_reg  <= col3_next;
            phase_reg <= phase_next;
            blue_reg  <= blue_next;
            green_reg <= green_next;
            base_reg  <= base_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mid_valid_reg <= 1'b0;
        else if (advance)
            mid_valid_reg <= pix_fire && emit;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            mid_reg <= mid_next;
    end

    assign mid_valid = mid_valid_reg;
    assign mid       = mid_reg;

endmodule

[hdl/dib_pixels_to_sprite_bytes.sv]
// Pipeline: an accepted input beat passes through the middle stage register, then the
// output register, before its result beat is presented.
// Throughput: one input beat per cycle; the palette read and position counters
// are registered and pipelined, so the stream only stalls on m_tready.
// Reset: configuration returns to 8bpp, 1x1 image; the pipeline empties.
// The palette keeps no reset and must be loaded before 8bpp pixels use it.
`timescale 1ns / 1ps

module dib_pixels_to_sprite_bytes
    import dibsp_pkg::*;
#(
    parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT    = DEF_MAX_HEIGHT,
    parameter int PALETTE_DEPTH = DEF_PALETTE_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [39:0]          s_tdata,   // data_byte, palette_index, palette_rgb
    input  logic                 s_tuser,   // func
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,   // out_offset, out_byte
    output logic                 m_tlast,   // last_of_image
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_wdata
);

    geom_t       geom;
    geom_t       geom_load;
    logic        restart;
    logic        advance;
    logic        in_fire;
    logic        pix_fire;
    logic        mid_valid;
    mid_t        mid;
    logic [23:0] pal_rgb;
    logic [7:0]  out_byte_next;

    logic                out_valid_reg;
    logic [OFFSET_W-1:0] out_offset_reg;
    logic [7:0]          out_byte_reg;
    logic                out_last_reg;

    // Hold the whole pipeline while a result beat waits
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = advance;
    assign in_fire  = s_tvalid && advance;
    assign pix_fire = in_fire && !s_tuser;

    dibsp_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .geom      (geom),
        .geom_load (geom_load),
        .restart   (restart)
    );

    dibsp_palette #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (in_fire && s_tuser),
        .wr_index (s_tdata[15:8]),
        .wr_rgb   (s_tdata[39:16]),
        .rd_en    (advance),
        .rd_index (s_tdata[7:0]),
        .rd_rgb   (pal_rgb)
    );

    dibsp_track u_track (
        .clk       (clk),
        .rst_n     (rst_n),
        .geom      (geom),
        .geom_load (geom_load),
        .restart   (restart),
        .advance   (advance),
        .pix_fire  (pix_fire),
        .data_byte (s_tdata[7:0]),
        .mid_valid (mid_valid),
        .mid       (mid)
    );

    assign out_byte_next = mid.use_palette
                         ? reduce_colour(pal_rgb[23:16], pal_rgb[15:8], pal_rgb[7:0])
                         : mid.direct_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= mid_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_offset_reg <= mid.offset;
            out_byte_reg   <= out_byte_next;
            out_last_reg   <= mid.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_byte_reg, out_offset_reg};
    assign m_tlast  = out_last_reg;

endmodule
